// ----- hw/rtl/wprb_pkg.sv -----
// Package for the waveform peak/RMS binner.
// Holds the item structs, the sequencer state type and shared constants.
// Depends on nothing; every RTL file of the block imports it.
package wprb_pkg;

    // Defaults for the top-level parameters.
    localparam int BINS_DEF        = 1024;
    localparam int COUNT_WIDTH_DEF = 24;

    // Fixed field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int SPB_W    = 24;
    localparam int BIN_W    = 10;
    localparam int LEVEL_W  = 8;
    localparam int SUM_W    = 55;

    // Shared multiplier: a 32-bit operand times a 16-bit operand.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Right side of the root test, 65025 * sum_squares, and the left side.
    localparam int RHS_W = SUM_W + 16;
    localparam int LHS_W = MUL_P_W + 30;

    localparam logic [SPB_W-1:0]   SPB_RESET  = 24'd1;
    localparam logic [MUL_B_W-1:0] RMS_SCALE  = 16'd65025;
    localparam logic [MUL_B_W-1:0] PEAK_SCALE = 16'd255;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_track;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] rms_level;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_ACC,
        S_RHS0,
        S_RHS1,
        S_RHS2,
        S_PEAK,
        S_RSQ,
        S_RMUL,
        S_RCMP,
        S_EMIT
    } t_state;

endpackage

// ----- hw/rtl/waveform_peak_rms_binner_core.sv -----
// A sample that does not close a bin passes through S_SQR and S_ACC, and the next item is taken
// back in S_IDLE. A sample that closes a bin goes on through S_RHS0, S_RHS1, S_RHS2, S_PEAK and
// the root search, and S_EMIT raises o_out_valid once the output register is free; an
// end-of-track item that flushes a partial bin starts at S_RHS0. Each bit of the 8-bit root
// search runs through S_RSQ, S_RMUL and S_RCMP on the shared multiplier. Input is not taken
// while an item is at work. Reset (i_rst_n low, synchronous) clears the bin index, the
// accumulators and the output valid, and sets samples_per_bin to 1.
//
// Top level of the waveform peak/RMS binner: sequencer, shared multiplier and datapath.
// Depends on wprb_pkg.
module waveform_peak_rms_binner_core
    import wprb_pkg::*;
#(
    parameter int BINS        = BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: samples_per_bin.
    input  logic              i_cfg_we,
    input  logic [SPB_W-1:0]  i_cfg_data,
    // Input items.
    input  logic              i_in_valid,
    input  t_in_item          i_in_item,
    output logic              o_in_stall,
    // Result items.
    output logic              o_out_valid,
    output t_out_item         o_out_item,
    input  logic              i_out_stall
);

    // The bin index must be able to hold BINS itself, which marks "all bins done".
    localparam int NB_W  = $clog2(BINS + 1);
    // Width at which the sample count is compared against samples_per_bin.
    localparam int CMP_W = (COUNT_WIDTH > SPB_W) ? COUNT_WIDTH : SPB_W;

    t_state r_state, n_state;

    // Bin state; reset and end of track clear all but r_spb, a closed bin clears peak, sum and count.
    logic [NB_W-1:0]        r_next_bin;
    logic [SAMPLE_W-1:0]    r_peak;
    logic [SUM_W-1:0]       r_sum;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [SPB_W-1:0]       r_spb;

    // Per-item working registers.
    logic [SAMPLE_W-1:0]    r_mag;
    logic                   r_eot;
    logic [MUL_P_W-1:0]     r_prod;
    logic [RHS_W-1:0]       r_rhs;
    logic [LEVEL_W-1:0]     r_peak_level;
    logic [LEVEL_W-1:0]     r_root;
    logic [2:0]             r_bit;

    // Output register.
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_done;
    logic [SAMPLE_W-1:0]    w_mag;
    logic [COUNT_WIDTH-1:0] w_count_inc;
    logic                   w_close;
    logic [LEVEL_W-1:0]     w_trial;
    logic                   w_fits;
    logic [MUL_A_W-1:0]     w_mul_a;
    logic [MUL_B_W-1:0]     w_mul_b;
    logic [31:0]            w_bin32;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    // The output register can take a new result when it is empty or being drained.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_done      = (r_next_bin >= NB_W'(BINS));

    // Magnitude of a two's complement sample; the most negative value gives 0x8000.
    assign w_mag = i_in_item.sample[SAMPLE_W-1]
                 ? SAMPLE_W'(~i_in_item.sample + 1'b1)
                 : SAMPLE_W'(i_in_item.sample);

    // The count wraps at its own width; a bin length of zero closes on every sample.
    assign w_count_inc = r_count + 1'b1;
    assign w_close     = (CMP_W'(w_count_inc) >= CMP_W'(r_spb));

    // Root search: the trial value sets the bit under test on top of the bits already kept.
    assign w_trial = r_root | (LEVEL_W'(1) << r_bit);
    // r*r*count*2^30 <= 65025*sum_squares, with r*r*count held in the product register.
    assign w_fits  = ({r_prod, 30'd0} <= LHS_W'(r_rhs));

    assign w_bin32 = 32'(r_next_bin);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_item.end_of_track) begin
                        if (!w_done && (r_count != '0)) begin
                            n_state = S_RHS0;
                        end
                    end else if (!w_done) begin
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR:  n_state = S_ACC;
            S_ACC:  n_state = w_close ? S_RHS0 : S_IDLE;
            S_RHS0: n_state = S_RHS1;
            S_RHS1: n_state = S_RHS2;
            S_RHS2: n_state = S_PEAK;
            S_PEAK: n_state = S_RSQ;
            S_RSQ:  n_state = S_RMUL;
            S_RMUL: n_state = S_RCMP;
            S_RCMP: n_state = (r_bit == 3'd0) ? S_EMIT : S_RSQ;
            S_EMIT: n_state = w_out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: input stall and the operands of the shared multiplier.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_mul_a    = '0;
        w_mul_b    = '0;
        case (r_state)
            S_SQR: begin
                w_mul_a = MUL_A_W'(r_mag);
                w_mul_b = r_mag;
            end
            S_RHS0: begin
                w_mul_a = r_sum[31:0];
                w_mul_b = RMS_SCALE;
            end
            S_RHS1: begin
                w_mul_a = MUL_A_W'(r_sum[SUM_W-1:32]);
                w_mul_b = RMS_SCALE;
            end
            S_RHS2: begin
                w_mul_a = MUL_A_W'(r_peak);
                w_mul_b = PEAK_SCALE;
            end
            S_RSQ: begin
                w_mul_a = MUL_A_W'(w_trial);
                w_mul_b = MUL_B_W'(w_trial);
            end
            S_RMUL: begin
                w_mul_a = MUL_A_W'(r_count);
                w_mul_b = r_prod[MUL_B_W-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Control registers and bin state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_next_bin  <= '0;
            r_peak      <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_spb       <= SPB_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_spb <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    // End of track with nothing to flush clears everything at once.
                    if (w_in_acc && i_in_item.end_of_track
                        && (w_done || (r_count == '0))) begin
                        r_next_bin <= '0;
                        r_peak     <= '0;
                        r_sum      <= '0;
                        r_count    <= '0;
                    end
                end
                S_ACC: begin
                    if (r_mag > r_peak) begin
                        r_peak <= r_mag;
                    end
                    r_sum   <= r_sum + SUM_W'(r_prod[30:0]);
                    r_count <= w_count_inc;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_next_bin  <= r_eot ? '0 : r_next_bin + 1'b1;
                        r_peak      <= '0;
                        r_sum       <= '0;
                        r_count     <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers and the shared multiplier; no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_mag <= w_mag;
                    r_eot <= i_in_item.end_of_track;
                end
            end
            S_RHS1: begin
                r_rhs <= RHS_W'(r_prod);
            end
            S_RHS2: begin
                r_rhs <= r_rhs + {r_prod[RHS_W-33:0], 32'd0};
            end
            S_PEAK: begin
                r_peak_level <= r_prod[22:15];
                r_root       <= '0;
                r_bit        <= 3'd7;
            end
            S_RCMP: begin
                if (w_fits) begin
                    r_root <= r_root | (LEVEL_W'(1) << r_bit);
                end
                r_bit <= r_bit - 1'b1;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out_item.bin_index  <= w_bin32[BIN_W-1:0];
                    r_out_item.peak_level <= r_peak_level;
                    r_out_item.rms_level  <= r_root;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // The bin index never runs past the "all bins done" mark.
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_bin <= NB_W'(BINS))
        else $error("bin index beyond BINS");

    // During the root search, the bit under test and all lower bits are still clear.
    a_root_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSQ) |-> ((r_root << (3'd7 - r_bit)) == '0))
        else $error("root bits set out of order");

    // A new result only appears from the emit step.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result raised outside the emit step");

    // End of track either starts a flush or leaves all bin state cleared.
    a_eot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.end_of_track) |=>
            ((r_state == S_RHS0) || ((r_next_bin == '0) && (r_count == '0))))
        else $error("end of track did not clear the bin state");
`endif

endmodule
